[hw/rtl/mhd_wave_speed_eigenvalues_core_macros.svh]
// Assertion macros used by the wave speed core top level.
`ifndef MHD_WAVE_SPEED_EIGENVALUES_CORE_MACROS_SVH
`define MHD_WAVE_SPEED_EIGENVALUES_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define MHD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define MHD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define MHD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define MHD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

[hw/rtl/mhd_wsc_pkg.sv]
// Shared constants and types for the wave speed core.
`default_nettype none
package mhd_wsc_pkg;
  localparam int FRAC_BITS = 16;
  localparam int WORD_BITS = 32;
  // square roots of Q values take a radicand widened by FRAC_BITS
  localparam int ROOT_IN_W = 64 + FRAC_BITS;
  localparam int ROOT_W    = (ROOT_IN_W + 1) / 2;

  localparam logic [17:0] GAMMA_RESET = 18'(((64'd10 << FRAC_BITS) + 64'd3) / 64'd6);
  localparam logic [0:0]  REG_GAMMA   = 1'b0;

  typedef struct packed {
    logic signed [31:0] u;
    logic               sat;
  } side_t;

  typedef struct packed {
    logic [63:0] a;
    logic [63:0] ca2;
    side_t       side;
  } carry_t;

  typedef struct packed {
    logic signed [31:0] fast_minus;
    logic signed [31:0] alfven_minus;
    logic signed [31:0] slow_minus;
    logic signed [31:0] entropy_speed;
    logic signed [31:0] slow_plus;
    logic signed [31:0] alfven_plus;
    logic signed [31:0] fast_plus;
    logic               saturated;
  } result_t;
endpackage
`default_nettype wire

[hw/rtl/mhd_wsc_if.sv]
// Valid/ready channel interfaces for cell input and eigenvalue output.
`default_nettype none
interface mhd_wsc_in_if;
  logic               valid;
  logic               ready;
  logic        [30:0] density;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_z;
  logic        [30:0] pressure;
  logic signed [31:0] field_x;
  logic signed [31:0] field_y;
  logic signed [31:0] field_z;
  modport source (output valid, density, vel_x, vel_y, vel_z, pressure,
                  field_x, field_y, field_z, input ready);
  modport sink (input valid, density, vel_x, vel_y, vel_z, pressure,
                field_x, field_y, field_z, output ready);
endinterface

interface mhd_wsc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] fast_minus;
  logic signed [31:0] alfven_minus;
  logic signed [31:0] slow_minus;
  logic signed [31:0] entropy_speed;
  logic signed [31:0] slow_plus;
  logic signed [31:0] alfven_plus;
  logic signed [31:0] fast_plus;
  logic               saturated;
  modport source (output valid, fast_minus, alfven_minus, slow_minus, entropy_speed,
                  slow_plus, alfven_plus, fast_plus, saturated, input ready);
  modport sink (input valid, fast_minus, alfven_minus, slow_minus, entropy_speed,
                slow_plus, alfven_plus, fast_plus, saturated, output ready);
endinterface
`default_nettype wire

[hw/rtl/mhd_wsc_div.sv]
// Pipelined restoring divider, three 64-bit dividends by one 31-bit divisor.
`default_nettype none
module mhd_wsc_div import mhd_wsc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  logic [30:0]      divisor,
  input  logic [2:0][63:0] num,
  input  side_t            in_side,
  output logic             out_vld,
  output logic [2:0][63:0] quo,
  output side_t            out_side
);
  localparam int NST = 64;

  typedef struct packed {
    logic [30:0] rem;
    logic [63:0] nq;
  } dl_t;

  function automatic dl_t div_step(input dl_t s, input logic [30:0] d);
    logic [31:0] trial;
    dl_t         r;
    trial = {s.rem, s.nq[63]};
    r.nq  = {s.nq[62:0], 1'b0};
    if (trial >= {1'b0, d}) begin
      r.rem   = 31'(trial - {1'b0, d});
      r.nq[0] = 1'b1;
    end else begin
      r.rem = trial[30:0];
    end
    return r;
  endfunction

  dl_t         ln_r [1:NST][3];
  logic [30:0] d_r  [1:NST];
  side_t       sd_r [1:NST];
  logic [NST:1] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-1:1], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r[1]  <= divisor;
      sd_r[1] <= in_side;
      for (int k = 0; k < 3; k++) ln_r[1][k] <= div_step({31'b0, num[k]}, divisor);
      for (int i = 2; i <= NST; i++) begin
        d_r[i]  <= d_r[i-1];
        sd_r[i] <= sd_r[i-1];
        for (int k = 0; k < 3; k++) ln_r[i][k] <= div_step(ln_r[i-1][k], d_r[i-1]);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) quo[k] = ln_r[NST][k].nq;
  end
  assign out_vld  = vld_r[NST];
  assign out_side = sd_r[NST];
endmodule
`default_nettype wire

[hw/rtl/mhd_wsc_disc.sv]
// Discriminant a*^2 - 4*cs2*ca2 from 32x32 partial products, clamped at zero.
`default_nettype none
module mhd_wsc_disc import mhd_wsc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         in_vld,
  input  logic [63:0]  cs2,
  input  carry_t       in_car,
  output logic         out_vld,
  output logic [127:0] disc,
  output carry_t       out_car
);
  logic [4:1]   vld_r;
  carry_t       car_r [1:4];
  logic [63:0]  aa00_r, aa01_r, aa11_r;
  logic [63:0]  f00_r, f01_r, f10_r, f11_r;
  logic [127:0] aa2_r;
  logic [64:0]  fmid_r;
  logic [63:0]  f00_2_r, f11_2_r;
  logic [127:0] aa3_r, four_r;
  logic [127:0] disc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:1], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // partial products
      aa00_r <= {32'b0, in_car.a[31:0]} * {32'b0, in_car.a[31:0]};
      aa01_r <= {32'b0, in_car.a[31:0]} * {32'b0, in_car.a[63:32]};
      aa11_r <= {32'b0, in_car.a[63:32]} * {32'b0, in_car.a[63:32]};
      f00_r  <= {32'b0, cs2[31:0]} * {32'b0, in_car.ca2[31:0]};
      f01_r  <= {32'b0, cs2[31:0]} * {32'b0, in_car.ca2[63:32]};
      f10_r  <= {32'b0, cs2[63:32]} * {32'b0, in_car.ca2[31:0]};
      f11_r  <= {32'b0, cs2[63:32]} * {32'b0, in_car.ca2[63:32]};
      car_r[1] <= in_car;
      // a*a; cross term counted twice
      aa2_r   <= {aa11_r, aa00_r} + ({63'b0, aa01_r, 1'b0} << 32);
      fmid_r  <= {1'b0, f01_r} + {1'b0, f10_r};
      f00_2_r <= f00_r;
      f11_2_r <= f11_r;
      car_r[2] <= car_r[1];
      // 4*cs2*ca2
      four_r <= ({f11_2_r, f00_2_r} + ({63'b0, fmid_r} << 32)) << 2;
      aa3_r  <= aa2_r;
      car_r[3] <= car_r[2];
      // rounding may push it negative
      disc_r <= (four_r <= aa3_r) ? (aa3_r - four_r) : '0;
      car_r[4] <= car_r[3];
    end
  end

  assign out_vld = vld_r[4];
  assign disc    = disc_r;
  assign out_car = car_r[4];
endmodule
`default_nettype wire

[hw/rtl/mhd_wsc_isqrt.sv]
// Pipelined floor square root of a 128-bit value, two radicand bits a stage.
`default_nettype none
module mhd_wsc_isqrt import mhd_wsc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic         in_vld,
  input  logic [127:0] rad,
  input  carry_t       in_car,
  output logic         out_vld,
  output logic [63:0]  root,
  output carry_t       out_car
);
  localparam int NST = 64;

  typedef struct packed {
    logic [65:0]  rem;
    logic [63:0]  rt;
    logic [127:0] x;
  } sl_t;

  function automatic sl_t sq_step(input sl_t s);
    logic [65:0] trial;
    logic [65:0] cand;
    sl_t         r;
    trial = {s.rem[63:0], s.x[127:126]};
    cand  = {s.rt, 2'b01};
    r.x   = {s.x[125:0], 2'b00};
    if (trial >= cand) begin
      r.rem = trial - cand;
      r.rt  = {s.rt[62:0], 1'b1};
    end else begin
      r.rem = trial;
      r.rt  = {s.rt[62:0], 1'b0};
    end
    return r;
  endfunction

  sl_t    ln_r  [1:NST];
  carry_t car_r [1:NST];
  logic [NST:1] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-1:1], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ln_r[1]  <= sq_step({66'b0, 64'b0, rad});
      car_r[1] <= in_car;
      for (int i = 2; i <= NST; i++) begin
        ln_r[i]  <= sq_step(ln_r[i-1]);
        car_r[i] <= car_r[i-1];
      end
    end
  end

  assign out_vld = vld_r[NST];
  assign root    = ln_r[NST].rt;
  assign out_car = car_r[NST];
endmodule
`default_nettype wire

[hw/rtl/mhd_wsc_root.sv]
// Three pipelined Q-format square roots (fast, Alfven, slow speeds).
`default_nettype none
module mhd_wsc_root import mhd_wsc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_vld,
  input  logic [2:0][63:0]       sq,
  input  side_t                  in_side,
  output logic                   out_vld,
  output logic [2:0][ROOT_W-1:0] rt,
  output side_t                  out_side
);
  localparam int NST = ROOT_W;
  localparam int XW  = 2 * ROOT_W;

  typedef struct packed {
    logic [ROOT_W+1:0] rem;
    logic [ROOT_W-1:0] r;
    logic [XW-1:0]     x;
  } rl_t;

  function automatic rl_t rt_step(input rl_t s);
    logic [ROOT_W+1:0] trial;
    logic [ROOT_W+1:0] cand;
    rl_t               o;
    trial = {s.rem[ROOT_W-1:0], s.x[XW-1:XW-2]};
    cand  = {s.r, 2'b01};
    o.x   = {s.x[XW-3:0], 2'b00};
    if (trial >= cand) begin
      o.rem = trial - cand;
      o.r   = {s.r[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem = trial;
      o.r   = {s.r[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

  rl_t   ln_r [1:NST][3];
  side_t sd_r [1:NST];
  logic [NST:1] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-1:1], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[1] <= in_side;
      for (int k = 0; k < 3; k++) begin
        ln_r[1][k] <= rt_step({{(ROOT_W+2){1'b0}}, {ROOT_W{1'b0}},
                               XW'({sq[k], {FRAC_BITS{1'b0}}})});
      end
      for (int i = 2; i <= NST; i++) begin
        sd_r[i] <= sd_r[i-1];
        for (int k = 0; k < 3; k++) ln_r[i][k] <= rt_step(ln_r[i-1][k]);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) rt[k] = ln_r[NST][k].r;
  end
  assign out_vld  = vld_r[NST];
  assign out_side = sd_r[NST];
endmodule
`default_nettype wire

[hw/rtl/mhd_wave_speed_eigenvalues_core.sv]
// Top level: ideal-MHD characteristic wave speed pipeline with APB register.
//
//  channel  | dir | handshake           | beat
//  ---------+-----+---------------------+-------------------------------------
//  in_ch    | in  | valid/ready         | one cell: rho, u, v, w, p, bx, by, bz
//  out_ch   | out | valid/ready         | seven eigenvalues plus saturated flag
//  APB      | in  | psel/penable/pwrite | gamma at byte address 0, pready tied
//
// One beat per clock sustained while not stalled. Stages to the output queue:
// front end 3, divider 64 (one quotient bit per stage), sum 1, discriminant 4,
// wide root 64 (one root bit per stage), speeds 1, Q roots ROOT_W = 40, clip 1.
// Reset (rst_n low, synchronous) empties every stage and loads gamma = 5/3.
// Stall freezes the whole pipe only when its last stage is full and the
// two-beat output queue is full and not draining; nothing is dropped.
`default_nettype none
`include "mhd_wave_speed_eigenvalues_core_macros.svh"
module mhd_wave_speed_eigenvalues_core import mhd_wsc_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  mhd_wsc_in_if.sink    in_ch,
  mhd_wsc_out_if.source out_ch,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  localparam int SUM_W = ROOT_W + 34;
  localparam logic signed [SUM_W-1:0] WMAX =
    {{(SUM_W-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] WMIN = ~WMAX;

  // clip to the signed word range; top bit flags a clip
  function automatic logic [32:0] clip_word(input logic signed [SUM_W-1:0] v);
    logic [32:0] r;
    if (v > WMAX) r = {1'b1, WMAX[31:0]};
    else if (v < WMIN) r = {1'b1, WMIN[31:0]};
    else r = {1'b0, v[31:0]};
    return r;
  endfunction

  // ---- register file
  logic [17:0] gamma_r;
  logic        cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2:2] == REG_GAMMA);
  assign prdata = (paddr[2:2] == REG_GAMMA) ? {14'b0, gamma_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gamma_r <= GAMMA_RESET;
    end else if (cfg_wr) begin
      gamma_r <= pwdata[17:0];
    end
  end

  // ---- global advance
  logic    en;
  logic    f_vld_r;
  result_t f_res_r;
  logic [1:0] q_cnt_r, q_cnt_nxt;
  logic       q_push, q_pop;

  assign en          = !f_vld_r || (q_cnt_r != 2'd2) || out_ch.ready;
  assign in_ch.ready = en;

  // ---- stage A: density guard, field magnitudes
  logic        a_vld_r;
  logic [30:0] a_rho_r, a_p_r;
  logic [31:0] a_bx_r, a_by_r, a_bz_r;
  side_t       a_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) a_vld_r <= 1'b0;
    else if (en) a_vld_r <= in_ch.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_rho_r      <= (in_ch.density == 31'd0) ? 31'd1 : in_ch.density;
      a_side_r.sat <= (in_ch.density == 31'd0);
      a_side_r.u   <= in_ch.vel_x;
      a_p_r        <= in_ch.pressure;
      a_bx_r <= in_ch.field_x[31] ? (~in_ch.field_x + 32'd1) : in_ch.field_x;
      a_by_r <= in_ch.field_y[31] ? (~in_ch.field_y + 32'd1) : in_ch.field_y;
      a_bz_r <= in_ch.field_z[31] ? (~in_ch.field_z + 32'd1) : in_ch.field_z;
    end
  end

  // ---- stage B: products
  logic        b_vld_r;
  logic [48:0] b_gp_r;
  logic [63:0] b_bx2_r, b_by2_r, b_bz2_r;
  logic [30:0] b_rho_r;
  side_t       b_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) b_vld_r <= 1'b0;
    else if (en) b_vld_r <= a_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_gp_r   <= {31'b0, gamma_r} * {18'b0, a_p_r};
      b_bx2_r  <= {32'b0, a_bx_r} * {32'b0, a_bx_r};
      b_by2_r  <= {32'b0, a_by_r} * {32'b0, a_by_r};
      b_bz2_r  <= {32'b0, a_bz_r} * {32'b0, a_bz_r};
      b_rho_r  <= a_rho_r;
      b_side_r <= a_side_r;
    end
  end

  // ---- stage C: dividends
  logic             c_vld_r;
  logic [2:0][63:0] c_num_r;
  logic [30:0]      c_rho_r;
  side_t            c_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) c_vld_r <= 1'b0;
    else if (en) c_vld_r <= b_vld_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_num_r[0] <= {15'b0, b_gp_r};
      c_num_r[1] <= b_bx2_r;
      c_num_r[2] <= b_by2_r + b_bz2_r;  // each at most 2^62, no carry out
      c_rho_r    <= b_rho_r;
      c_side_r   <= b_side_r;
    end
  end

  // ---- cs2, ca2, bt2
  logic             dv_vld;
  logic [2:0][63:0] dv_q;
  side_t            dv_side;

  mhd_wsc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (c_vld_r),
    .divisor  (c_rho_r),
    .num      (c_num_r),
    .in_side  (c_side_r),
    .out_vld  (dv_vld),
    .quo      (dv_q),
    .out_side (dv_side)
  );

  // ---- stage D: a* = cs2 + ca2 + bt2 (fits 64 bits by range)
  logic        d_vld_r;
  logic [63:0] d_cs2_r;
  carry_t      d_car_r;

  always_ff @(posedge clk) begin
    if (!rst_n) d_vld_r <= 1'b0;
    else if (en) d_vld_r <= dv_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_cs2_r      <= dv_q[0];
      d_car_r.a    <= dv_q[0] + dv_q[1] + dv_q[2];
      d_car_r.ca2  <= dv_q[1];
      d_car_r.side <= dv_side;
    end
  end

  logic         ds_vld;
  logic [127:0] ds_disc;
  carry_t       ds_car;

  mhd_wsc_disc u_disc (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (d_vld_r),
    .cs2     (d_cs2_r),
    .in_car  (d_car_r),
    .out_vld (ds_vld),
    .disc    (ds_disc),
    .out_car (ds_car)
  );

  logic        sq_vld;
  logic [63:0] sq_root;
  carry_t      sq_car;

  mhd_wsc_isqrt u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (ds_vld),
    .rad     (ds_disc),
    .in_car  (ds_car),
    .out_vld (sq_vld),
    .root    (sq_root),
    .out_car (sq_car)
  );

  // ---- stage E: fast and slow speeds squared, halved with floor; ca2 passed on
  logic             e_vld_r;
  logic [2:0][63:0] e_v_r;
  side_t            e_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) e_vld_r <= 1'b0;
    else if (en) e_vld_r <= sq_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_v_r[0] <= (sq_car.a >> 1) + (sq_root >> 1) + {63'b0, sq_car.a[0] & sq_root[0]};
      e_v_r[1] <= sq_car.ca2;
      e_v_r[2] <= (sq_root <= sq_car.a) ? ((sq_car.a - sq_root) >> 1) : 64'b0;
      e_side_r <= sq_car.side;
    end
  end

  logic                   rt_vld;
  logic [2:0][ROOT_W-1:0] rt_root;
  side_t                  rt_side;

  mhd_wsc_root u_root (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (e_vld_r),
    .sq       (e_v_r),
    .in_side  (e_side_r),
    .out_vld  (rt_vld),
    .rt       (rt_root),
    .out_side (rt_side)
  );

  // ---- stage F: u -/+ speeds, clip
  logic signed [SUM_W-1:0] u_x;
  logic signed [SUM_W-1:0] c_x [3];
  logic signed [SUM_W-1:0] sum [7];
  logic [32:0]             clp [7];
  logic                    f_sat;

  always_comb begin
    u_x = SUM_W'(rt_side.u);
    for (int k = 0; k < 3; k++) c_x[k] = $signed({{(SUM_W-ROOT_W){1'b0}}, rt_root[k]});
    sum[0] = u_x - c_x[0];
    sum[1] = u_x - c_x[1];
    sum[2] = u_x - c_x[2];
    sum[3] = u_x;
    sum[4] = u_x + c_x[2];
    sum[5] = u_x + c_x[1];
    sum[6] = u_x + c_x[0];
    f_sat = rt_side.sat;
    for (int i = 0; i < 7; i++) begin
      clp[i] = clip_word(sum[i]);
      f_sat  = f_sat | clp[i][32];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) f_vld_r <= 1'b0;
    else if (en) f_vld_r <= rt_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_res_r.fast_minus    <= clp[0][31:0];
      f_res_r.alfven_minus  <= clp[1][31:0];
      f_res_r.slow_minus    <= clp[2][31:0];
      f_res_r.entropy_speed <= clp[3][31:0];
      f_res_r.slow_plus     <= clp[4][31:0];
      f_res_r.alfven_plus   <= clp[5][31:0];
      f_res_r.fast_plus     <= clp[6][31:0];
      f_res_r.saturated     <= f_sat;
    end
  end

  // ---- two-beat output queue
  result_t q_r [2];
  logic    q_wp_r, q_rp_r;

  assign q_push    = en && f_vld_r;
  assign q_pop     = out_ch.valid && out_ch.ready;
  assign q_cnt_nxt = q_cnt_r + {1'b0, q_push} - {1'b0, q_pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= 2'd0;
      q_wp_r  <= 1'b0;
      q_rp_r  <= 1'b0;
    end else begin
      q_cnt_r <= q_cnt_nxt;
      if (q_push) q_wp_r <= ~q_wp_r;
      if (q_pop)  q_rp_r <= ~q_rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) q_r[q_wp_r] <= f_res_r;
  end

  assign out_ch.valid         = (q_cnt_r != 2'd0);
  assign out_ch.fast_minus    = q_r[q_rp_r].fast_minus;
  assign out_ch.alfven_minus  = q_r[q_rp_r].alfven_minus;
  assign out_ch.slow_minus    = q_r[q_rp_r].slow_minus;
  assign out_ch.entropy_speed = q_r[q_rp_r].entropy_speed;
  assign out_ch.slow_plus     = q_r[q_rp_r].slow_plus;
  assign out_ch.alfven_plus   = q_r[q_rp_r].alfven_plus;
  assign out_ch.fast_plus     = q_r[q_rp_r].fast_plus;
  assign out_ch.saturated     = q_r[q_rp_r].saturated;

  // ---- checks
  `MHD_ASSERT_IMP(a_q_cap, clk, rst_n, 1'b1, q_cnt_r <= 2'd2, "output queue overfilled")
  `MHD_ASSERT_NXT(a_tail_hold, clk, rst_n, f_vld_r && !en, f_vld_r && $stable(f_res_r),
                  "stalled tail beat changed")
  `MHD_ASSERT_NXT(a_q_drain, clk, rst_n, q_pop && !q_push, q_cnt_r == $past(q_cnt_r) - 2'd1,
                  "queue count wrong after pop")
endmodule
`default_nettype wire
